[hw/rtl/remote_command_frame_receiver_core_macros.svh]
// Assertion macros used by the frame receiver RTL.
`ifndef REMOTE_COMMAND_FRAME_RECEIVER_CORE_MACROS_SVH
`define REMOTE_COMMAND_FRAME_RECEIVER_CORE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define RCFR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence on the next clock edge.
`define RCFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/rcfr_pkg.sv]
// Types, constants and mode update rule of the remote command frame receiver.
package rcfr_pkg;

    localparam logic [7:0] HDR_BYTE = 8'hA5;
    localparam logic [7:0] TRL_BYTE = 8'h5A;
    localparam logic [7:0] SWITCH_LIMIT_RST = 8'd90;
    localparam logic [7:0] RESTART_CODE = 8'd1;

    localparam logic signed [7:0] THR_LOW  = 8'sd33;
    localparam logic signed [7:0] THR_MID  = 8'sd66;
    localparam logic signed [7:0] THR_HIGH = 8'sd100;

    typedef enum logic [1:0] {
        MODE_LOW  = 2'd0,
        MODE_MID  = 2'd1,
        MODE_HIGH = 2'd2
    } t_mode;

    typedef struct packed {
        logic signed [7:0] joy_a;
        logic signed [7:0] joy_b;
        logic signed [7:0] joy_c;
        logic signed [7:0] joy_d;
        logic [7:0]        flag_value;
        logic [1:0]        flight_mode;
        logic              restart_request;
    } t_result;

    function automatic t_mode next_mode(input t_mode mode, input logic signed [7:0] b6,
                                        input logic allowed);
        t_mode res;
        res = mode;
        priority if (allowed && b6 < THR_LOW && mode == MODE_MID) begin
            res = MODE_LOW;
        end else if (allowed && b6 < THR_MID && (mode == MODE_LOW || mode == MODE_MID)) begin
            res = MODE_MID;
        end else if (allowed && b6 < THR_HIGH && mode == MODE_MID) begin
            res = MODE_HIGH;
        end else begin
            res = mode;
        end
        return res;
    endfunction

endpackage

[hw/rtl/rcfr_frame_asm.sv]
// Frame assembly: position counter, frame byte store, flight mode and result decode.
`include "remote_command_frame_receiver_core_macros.svh"

module rcfr_frame_asm #(
    parameter int FRAME_LEN = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_advance,
    input  logic [7:0]            i_rx_byte,
    input  logic [7:0]            i_switch_channel,
    input  logic [7:0]            i_switch_limit,
    output logic                  o_fire,
    output rcfr_pkg::t_result     o_result
);

    localparam int POS_W = $clog2(FRAME_LEN);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);

    logic [POS_W-1:0]  r_pos;
    logic [POS_W-1:0]  n_pos;
    logic [7:0]        r_frame [1:7];
    rcfr_pkg::t_mode   r_mode;
    rcfr_pkg::t_mode   n_mode;
    logic              is_wait;
    logic              is_good_end;
    logic              allowed;

    always_comb begin
        is_wait     = (r_pos == '0) && (i_rx_byte != rcfr_pkg::HDR_BYTE);
        is_good_end = (r_pos == LAST_POS) && (i_rx_byte == rcfr_pkg::TRL_BYTE);
        allowed     = i_switch_channel < i_switch_limit;
        n_mode      = rcfr_pkg::next_mode(r_mode, $signed(r_frame[6]), allowed);
        priority if (is_wait || r_pos == LAST_POS) begin
            n_pos = '0;
        end else begin
            n_pos = r_pos + 1'b1;
        end
        o_fire                   = i_advance && is_good_end;
        o_result.joy_a           = $signed(r_frame[1]);
        o_result.joy_b           = $signed(r_frame[2]);
        o_result.joy_c           = $signed(r_frame[3]);
        o_result.joy_d           = $signed(r_frame[4]);
        o_result.flag_value      = r_frame[5];
        o_result.flight_mode     = n_mode;
        o_result.restart_request = r_frame[7] == rcfr_pkg::RESTART_CODE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_mode <= rcfr_pkg::MODE_LOW;
        end else if (i_advance) begin
            r_pos <= n_pos;
            if (is_good_end) begin
                r_mode <= n_mode;
            end
        end
    end

    for (genvar g = 1; g <= 7; g++) begin : g_store
        always_ff @(posedge i_clk) begin
            if (i_advance && r_pos == POS_W'(g)) begin
                r_frame[g] <= i_rx_byte;
            end
        end
    end

    `RCFR_ASSERT(a_pos_range, r_pos <= LAST_POS, "frame position out of range")
    `RCFR_ASSERT(a_fire_at_last, !o_fire || r_pos == LAST_POS, "result away from trailer")
    `RCFR_ASSERT_NEXT(a_mode_hold, !o_fire, $stable(r_mode), "mode changed without a frame")
    `RCFR_ASSERT_NEXT(a_hdr_wait, i_advance && is_wait, r_pos == '0, "left header wait")

endmodule

[hw/rtl/rcfr_out_reg.sv]
// Result register with valid/ready handshake on the output channel.
module rcfr_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  rcfr_pkg::t_result i_result,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output rcfr_pkg::t_result o_result
);

    logic              r_valid;
    rcfr_pkg::t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_result    = r_result;

endmodule

[hw/rtl/remote_command_frame_receiver_core.sv]
// Top level of the remote command frame receiver: input register, flow control, config.
//
//  Channel   Direction  Signals                                    Transfer when
//  in        sink       i_in_valid/o_in_ready, rx_byte, switch_ch  valid & ready
//  out       source     o_out_valid/i_out_ready, result fields     valid & ready
//  cfg       sink       i_cfg_we, i_cfg_data (switch_limit)        i_cfg_we
//
//  One byte per cycle unless output stalls; each byte first enters the input register.
//  The input register empties into the frame logic whenever the result register is free.
//  A stalled output holds the result; one more byte waits in the input register.
//  Synchronous reset clears position, mode, valids and sets switch_limit to 90.
module remote_command_frame_receiver_core #(
    parameter int FRAME_LEN = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [7:0]        i_rx_byte,
    input  logic [7:0]        i_switch_channel,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic signed [7:0] o_joy_a,
    output logic signed [7:0] o_joy_b,
    output logic signed [7:0] o_joy_c,
    output logic signed [7:0] o_joy_d,
    output logic [7:0]        o_flag_value,
    output logic [1:0]        o_flight_mode,
    output logic              o_restart_request,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_data
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic [7:0]        r_in_switch;
    logic [7:0]        r_switch_limit;
    logic              advance;
    logic              fire;
    rcfr_pkg::t_result asm_result;
    rcfr_pkg::t_result out_result;

    assign advance    = r_in_valid && (!o_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_switch_limit <= rcfr_pkg::SWITCH_LIMIT_RST;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (i_cfg_we) begin
                r_switch_limit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte   <= i_rx_byte;
            r_in_switch <= i_switch_channel;
        end
    end

    rcfr_frame_asm #(
        .FRAME_LEN (FRAME_LEN)
    ) u_frame_asm (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_advance        (advance),
        .i_rx_byte        (r_in_byte),
        .i_switch_channel (r_in_switch),
        .i_switch_limit   (r_switch_limit),
        .o_fire           (fire),
        .o_result         (asm_result)
    );

    rcfr_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (fire),
        .i_result    (asm_result),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_result    (out_result)
    );

    assign o_joy_a           = out_result.joy_a;
    assign o_joy_b           = out_result.joy_b;
    assign o_joy_c           = out_result.joy_c;
    assign o_joy_d           = out_result.joy_d;
    assign o_flag_value      = out_result.flag_value;
    assign o_flight_mode     = out_result.flight_mode;
    assign o_restart_request = out_result.restart_request;

endmodule
